>>> design/smf_pkg.sv
// Shared constants, register codes and the cell link type of the sliding median filter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package smf_pkg;

	localparam int CODE_W = 10;
	localparam int SCALE_W = 8;
	localparam int VAC_W = 15;
	localparam int PROD_W = CODE_W + SCALE_W;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int WINDOW_DEF = 31;

	localparam logic [VAC_W-1:0] VAC_MAX = 15'd25600;

	localparam logic [CODE_W-1:0] FAULT_LOW_RST = 10'd82;
	localparam logic [CODE_W-1:0] FAULT_HIGH_RST = 10'd982;
	localparam logic [CODE_W-1:0] ATM_RST = 10'd921;
	localparam logic [SCALE_W-1:0] SCALE_RST = 8'd31;

	localparam logic [1:0] REG_FAULT_LOW = 2'd0;
	localparam logic [1:0] REG_FAULT_HIGH = 2'd1;
	localparam logic [1:0] REG_ATM = 2'd2;
	localparam logic [1:0] REG_SCALE = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic le;
		logic del;
	} link_t;

endpackage

>>> design/sliding_median_pressure_filter_top.sv
// Top level of the sliding median pressure filter: register port, sample pipeline,
// fault latch and vacuum conversion. Depends on smf_pkg and smf_chain.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_stall    adc_sample
//   result    out        result_valid / result_stall    filtered_code, vacuum_q8,
//                                                       warming_up, sensor_fault
//   config    in         APB psel / penable / pready    paddr, pwdata, prdata
//
// One request is taken per cycle unless a stalled result holds the pipeline. The cell row
// evicts the oldest and inserts the new sample at the accepting edge, together with the
// valid_s1 stage; the median, fault and vacuum then go into the output registers.
// Reset clears the fill count, the fault latch and the pipeline valid bits.
// A stalled result holds the pipeline and stalls the sample side in the same cycle.
`timescale 1ns / 1ps
module sliding_median_pressure_filter_top import smf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [CODE_W-1:0]  adc_sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [CODE_W-1:0]  filtered_code,
	output logic [VAC_W-1:0]   vacuum_q8,
	output logic               warming_up,
	output logic               sensor_fault,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [CODE_W-1:0] fault_low_q;
	logic [CODE_W-1:0] fault_high_q;
	logic [CODE_W-1:0] atm_q;
	logic [SCALE_W-1:0] scale_q;
	logic [1:0] reg_idx;

	logic advance;
	logic accept;
	logic warm_next;
	logic [CODE_W-1:0] median;

	logic valid_s1;
	logic [CODE_W-1:0] raw_s1;
	logic warm_s1;

	logic [CODE_W-1:0] code;
	logic fault_next;
	logic [CODE_W-1:0] diff;
	logic [PROD_W-1:0] prod;
	logic [VAC_W-1:0] vac;

	logic out_valid_q;
	logic fault_q;
	logic [CODE_W-1:0] code_q;
	logic [VAC_W-1:0] vac_q;
	logic warm_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_low_q <= FAULT_LOW_RST;
			fault_high_q <= FAULT_HIGH_RST;
			atm_q <= ATM_RST;
			scale_q <= SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_FAULT_LOW: fault_low_q <= pwdata[CODE_W-1:0];
				REG_FAULT_HIGH: fault_high_q <= pwdata[CODE_W-1:0];
				REG_ATM: atm_q <= pwdata[CODE_W-1:0];
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FAULT_LOW: prdata = DATA_W'(fault_low_q);
			REG_FAULT_HIGH: prdata = DATA_W'(fault_high_q);
			REG_ATM: prdata = DATA_W'(atm_q);
			REG_SCALE: prdata = DATA_W'(scale_q);
			default: prdata = '0;
		endcase
	end

	assign advance = !out_valid_q || !result_stall;
	assign sample_stall = !advance;
	assign accept = sample_valid && advance;

	smf_chain #(
		.WINDOW(WINDOW)
	) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.new_code(adc_sample),
		.warm_next(warm_next),
		.median(median)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= adc_sample;
			warm_s1 <= warm_next;
		end
	end

	assign code = warm_s1 ? raw_s1 : median;
	assign fault_next = fault_q || (code < fault_low_q) || (code > fault_high_q);
	assign diff = atm_q - code;
	assign prod = PROD_W'(diff) * PROD_W'(scale_q);

	always_comb begin
		if (fault_next || !(atm_q > code)) begin
			vac = '0;
		end else if (prod > PROD_W'(VAC_MAX)) begin
			vac = VAC_MAX;
		end else begin
			vac = prod[VAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fault_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				fault_q <= fault_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			code_q <= code;
			vac_q <= vac;
			warm_q <= warm_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign filtered_code = code_q;
	assign vacuum_q8 = vac_q;
	assign warming_up = warm_q;
	assign sensor_fault = fault_q;

	a_fault_latches: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q) else $error("sensor fault latch cleared without reset");
	a_fault_zero_vac: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sensor_fault |-> vacuum_q8 == '0)
		else $error("nonzero vacuum reported with a sensor fault");
	a_vac_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> vacuum_q8 <= VAC_MAX) else $error("vacuum above the clamp");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> out_valid_q && result_stall)
		else $error("sample side stalled without a blocked result");

endmodule

>>> design/smf_cell.sv
// One cell of the sorted window: holds a sample code and its age in the window.
// Depends on smf_pkg for the link type between neighboring cells.
`timescale 1ns / 1ps
module smf_cell import smf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int AGE_W = $clog2(WINDOW)
) (
	input  logic              clk,
	input  logic              step,
	input  logic              full,
	input  logic              a_valid,
	input  logic [CODE_W-1:0] new_code,
	input  logic [CODE_W-1:0] up_code,
	input  logic [AGE_W-1:0]  up_age,
	input  link_t             low_link,
	input  logic [AGE_W-1:0]  low_age,
	output logic [CODE_W-1:0] cell_code,
	output logic [AGE_W-1:0]  cell_age,
	output link_t             link,
	output logic [AGE_W-1:0]  a_age
);

	logic [CODE_W-1:0] code_q;
	logic [AGE_W-1:0] age_q;
	logic old;

	// The oldest sample leaves when the window is full; cells above it close the gap,
	// then the new sample opens a gap at its sorted place.
	assign old = full && (age_q == AGE_W'(WINDOW - 1));
	assign link.del = low_link.del | old;
	assign link.code = link.del ? up_code : code_q;
	assign a_age = link.del ? up_age : age_q;
	assign link.le = a_valid && (link.code <= new_code);

	always_ff @(posedge clk) begin
		if (step) begin
			if (link.le) begin
				code_q <= link.code;
				age_q <= a_age + AGE_W'(1);
			end else if (low_link.le) begin
				code_q <= new_code;
				age_q <= '0;
			end else begin
				code_q <= low_link.code;
				age_q <= low_age + AGE_W'(1);
			end
		end
	end

	assign cell_code = code_q;
	assign cell_age = age_q;

endmodule

>>> design/smf_chain.sv
// Row of sorted window cells with the fill count; gives the window median.
// Depends on smf_pkg and smf_cell.
`timescale 1ns / 1ps
module smf_chain import smf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CODE_W-1:0] new_code,
	output logic              warm_next,
	output logic [CODE_W-1:0] median
);

	localparam int AGE_W = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int MID = WINDOW / 2;

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] a_cnt;
	logic full;

	logic [CODE_W-1:0] cell_code [WINDOW];
	logic [AGE_W-1:0] cell_age [WINDOW];
	link_t link [WINDOW];
	logic [AGE_W-1:0] a_age [WINDOW];

	assign full = (fill_q == FILL_W'(WINDOW));
	assign a_cnt = full ? FILL_W'(WINDOW - 1) : fill_q;
	assign warm_next = (fill_q < FILL_W'(WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step && !full) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	genvar i;
	generate
		for (i = 0; i < WINDOW; i++) begin : g_cell
			localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
			link_t low_link;
			logic [AGE_W-1:0] low_age;
			logic [CODE_W-1:0] up_code;
			logic [AGE_W-1:0] up_age;

			if (i == 0) begin : g_first
				assign low_link = '{code: '0, le: 1'b1, del: 1'b0};
				assign low_age = '0;
			end else begin : g_mid
				assign low_link = link[i-1];
				assign low_age = a_age[i-1];
			end

			if (i == WINDOW - 1) begin : g_last
				assign up_code = '0;
				assign up_age = '0;
			end else begin : g_below
				assign up_code = cell_code[i+1];
				assign up_age = cell_age[i+1];
			end

			smf_cell #(
				.WINDOW(WINDOW),
				.AGE_W(AGE_W)
			) u_cell (
				.clk(clk),
				.step(step),
				.full(full),
				.a_valid(IDX < a_cnt),
				.new_code(new_code),
				.up_code(up_code),
				.up_age(up_age),
				.low_link(low_link),
				.low_age(low_age),
				.cell_code(cell_code[i]),
				.cell_age(cell_age[i]),
				.link(link[i]),
				.a_age(a_age[i])
			);
		end
	endgenerate

	assign median = cell_code[MID];

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> full) else $error("window fill count left the full state");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW)) else $error("fill count beyond the window size");
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		step && full |-> link[WINDOW-1].del) else $error("full window without an oldest cell");

endmodule

>>> sim/smf_filter_checker.sv
// Checker for the sliding median pressure filter: watches the sample, result and register
// ports, predicts each filtered reading and compares it field by field. Depends on smf_pkg.
`timescale 1ns / 1ps
module smf_filter_checker import smf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  logic [CODE_W-1:0]  adc_sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [CODE_W-1:0]  filtered_code,
	input  logic [VAC_W-1:0]   vacuum_q8,
	input  logic               warming_up,
	input  logic               sensor_fault,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic [DATA_W-1:0]  prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 readings_due
);

	localparam int DEPTH = WINDOW_DEF;

	typedef struct {
		logic [CODE_W-1:0] code;
		logic [VAC_W-1:0]  vacuum;
		logic              warm;
		logic              fault;
	} reading_t;

	reading_t expected_readings[$];
	reading_t head;
	logic [CODE_W-1:0] lo_code;
	logic [CODE_W-1:0] hi_code;
	logic [CODE_W-1:0] atm_code;
	logic [SCALE_W-1:0] scale;
	logic [CODE_W-1:0] ring[DEPTH];
	int ring_pos;
	int ring_fill;
	logic fault_seen;
	int mismatches = 0;
	int due = 0;

	assign fail_count = mismatches;
	assign readings_due = due;

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [CODE_W-1:0] ring_median();
		logic [CODE_W-1:0] sorted[DEPTH];
		logic [CODE_W-1:0] v;
		int j;
		sorted = ring;
		for (int i = 1; i < DEPTH; i++) begin
			v = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[DEPTH/2];
	endfunction

	function automatic reading_t predict_pressure(input logic [CODE_W-1:0] sample);
		reading_t r;
		int product;
		ring[ring_pos] = sample;
		ring_pos = (ring_pos + 1) % DEPTH;
		if (ring_fill < DEPTH)
			ring_fill++;
		r.warm = ring_fill < DEPTH;
		r.code = r.warm ? sample : ring_median();
		if (r.code < lo_code || r.code > hi_code)
			fault_seen = 1'b1;
		r.fault = fault_seen;
		r.vacuum = '0;
		if (!fault_seen && atm_code > r.code) begin
			product = (int'(atm_code) - int'(r.code)) * int'(scale);
			r.vacuum = product > int'(VAC_MAX) ? VAC_MAX : VAC_W'(product);
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] register_value(input logic [1:0] idx);
		case (idx)
			REG_FAULT_LOW:  return DATA_W'(lo_code);
			REG_FAULT_HIGH: return DATA_W'(hi_code);
			REG_ATM:        return DATA_W'(atm_code);
			default:        return DATA_W'(scale);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_code = FAULT_LOW_RST;
			hi_code = FAULT_HIGH_RST;
			atm_code = ATM_RST;
			scale = SCALE_RST;
			for (int i = 0; i < DEPTH; i++)
				ring[i] = '0;
			ring_pos = 0;
			ring_fill = 0;
			fault_seen = 1'b0;
			expected_readings.delete();
			due = 0;
		end else begin
			if (sample_valid && !sample_stall)
				expected_readings.push_back(predict_pressure(adc_sample));
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					flag_mismatch($sformatf("result code %0d with no request pending",
						filtered_code));
				end else begin
					head = expected_readings.pop_front();
					if (filtered_code !== head.code)
						flag_mismatch($sformatf("filtered_code got %0d expected %0d",
							filtered_code, head.code));
					if (vacuum_q8 !== head.vacuum)
						flag_mismatch($sformatf("vacuum_q8 got %0d expected %0d",
							vacuum_q8, head.vacuum));
					if (warming_up !== head.warm)
						flag_mismatch($sformatf("warming_up got %0b expected %0b",
							warming_up, head.warm));
					if (sensor_fault !== head.fault)
						flag_mismatch($sformatf("sensor_fault got %0b expected %0b",
							sensor_fault, head.fault));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_FAULT_LOW:  lo_code = pwdata[CODE_W-1:0];
						REG_FAULT_HIGH: hi_code = pwdata[CODE_W-1:0];
						REG_ATM:        atm_code = pwdata[CODE_W-1:0];
						REG_SCALE:      scale = pwdata[SCALE_W-1:0];
						default: ;
					endcase
				end else if (prdata !== register_value(paddr[3:2])) begin
					flag_mismatch($sformatf("register %0d read %0h expected %0h",
						paddr[3:2], prdata, register_value(paddr[3:2])));
				end
			end
			due = expected_readings.size();
		end
	end

endmodule

>>> sim/tb_sliding_median_pressure_filter_top.sv
// Testbench top for the sliding median pressure filter: clock, reset, sample and register
// stimulus with random gaps and stalls, and the verdict. Depends on smf_pkg and smf_filter_checker.
`timescale 1ns / 1ps
module tb_sliding_median_pressure_filter_top;
	import smf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [CODE_W-1:0] adc_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [CODE_W-1:0] filtered_code;
	logic [VAC_W-1:0] vacuum_q8;
	logic warming_up;
	logic sensor_fault;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic calm = 1'b0;
	int cycles = 0;
	int errors;
	int due;

	sliding_median_pressure_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.adc_sample(adc_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.filtered_code(filtered_code),
		.vacuum_q8(vacuum_q8),
		.warming_up(warming_up),
		.sensor_fault(sensor_fault),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	smf_filter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.adc_sample(adc_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.filtered_code(filtered_code),
		.vacuum_q8(vacuum_q8),
		.warming_up(warming_up),
		.sensor_fault(sensor_fault),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(errors),
		.readings_due(due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 14);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [CODE_W-1:0] draw_sample(input int centre, input int spread);
		int v;
		if ($urandom_range(0, 99) < 8)
			return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return CODE_W'(v);
	endfunction

	task automatic send_sample(input logic [CODE_W-1:0] value);
		while (!calm && $urandom_range(0, 99) < 14) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= value;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic write, input logic [DATA_W-1:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int value);
		logic [DATA_W-1:0] word;
		word = $urandom();
		if (idx == REG_SCALE)
			word[SCALE_W-1:0] = value[SCALE_W-1:0];
		else
			word[CODE_W-1:0] = value[CODE_W-1:0];
		apb_access(idx, 1'b1, word);
	endtask

	task automatic read_all();
		apb_access(REG_FAULT_LOW, 1'b0, $urandom());
		apb_access(REG_FAULT_HIGH, 1'b0, $urandom());
		apb_access(REG_ATM, 1'b0, $urandom());
		apb_access(REG_SCALE, 1'b0, $urandom());
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int base;
		int spread;
		int atm;
		int scale_pick;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		read_all();

		// Reset limits: both boundary codes pass, a code above atmosphere gives no vacuum.
		send_sample(10'd82);
		send_sample(10'd982);
		send_sample(10'd921);
		send_sample(10'd920);
		repeat (8) send_sample(CODE_W'($urandom_range(100, 950)));
		settle();

		cfg_write(REG_FAULT_LOW, 0);
		cfg_write(REG_FAULT_HIGH, 1023);
		cfg_write(REG_ATM, 1023);
		cfg_write(REG_SCALE, 255);
		read_all();
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd1022);
		send_sample(10'd1000);
		send_sample(10'd923);
		send_sample(10'd922);
		send_sample(10'd512);
		send_sample(10'h155);
		send_sample(10'h2AA);

		for (int p = 0; p < 22; p++) begin
			settle();
			base = $urandom_range(0, 1023);
			case ($urandom_range(0, 3))
				0: atm = 0;
				1: atm = 1023;
				default: atm = base + int'($urandom_range(0, 160)) - 20;
			endcase
			if (atm < 0)
				atm = 0;
			if (atm > 1023)
				atm = 1023;
			case ($urandom_range(0, 3))
				0: scale_pick = 0;
				1: scale_pick = 255;
				default: scale_pick = $urandom_range(1, 255);
			endcase
			cfg_write(REG_ATM, atm);
			cfg_write(REG_SCALE, scale_pick);
			if (p % 6 == 0)
				read_all();
			case ($urandom_range(0, 3))
				0: spread = 2;
				1: spread = 30;
				2: spread = 200;
				default: spread = 1024;
			endcase
			calm = (p == 5);
			repeat (p == 5 ? 160 : 64) send_sample(draw_sample(base, spread));
			calm = 1'b0;
		end

		// Fill the window in range, tighten the limits, then drive the median over the top.
		settle();
		cfg_write(REG_ATM, 900);
		cfg_write(REG_SCALE, 40);
		repeat (40) send_sample(CODE_W'($urandom_range(300, 700)));
		settle();
		cfg_write(REG_FAULT_LOW, 200);
		cfg_write(REG_FAULT_HIGH, 800);
		read_all();
		repeat (30) send_sample(CODE_W'($urandom_range(300, 700)));
		repeat (40) send_sample(CODE_W'($urandom_range(850, 1023)));
		repeat (60) send_sample(draw_sample(512, 512));
		settle();
		cfg_write(REG_FAULT_LOW, 1023);
		cfg_write(REG_FAULT_HIGH, 0);
		read_all();
		repeat (20) send_sample(draw_sample(512, 512));
		settle();
		repeat (6) @(negedge clk);

		if (errors == 0 && due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
